// ===== src/des_key_schedule_macros.svh =====
// assertion macros used by the des key schedule back module (dks_back)
// expects clk and rst_n in the scope where a macro is used
`ifndef DES_KEY_SCHEDULE_MACROS_SVH
`define DES_KEY_SCHEDULE_MACROS_SVH

// same-cycle implication, checked outside reset
`define DKS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("des key schedule check failed");

// next-cycle implication, checked outside reset
`define DKS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("des key schedule check failed");

`endif

// ===== src/dks_pkg.sv =====
// des key schedule package: widths, permutation tables, front-to-back item type
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package dks_pkg;

    localparam int KEY_W   = 64;
    localparam int HALF_W  = 28;
    localparam int CD_W    = 2 * HALF_W;
    localparam int SUB_W   = 48;
    localparam int ROUNDS  = 16;
    localparam int RND_W   = $clog2(ROUNDS);
    localparam int RNUM_W  = 5;

    typedef logic [6:0] tab_entry_t;

    // pc1 key selection, source bit numbers counted from the msb
    localparam tab_entry_t PC1_TAB [CD_W] = '{
        7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,
        7'd1,  7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18,
        7'd10, 7'd2,  7'd59, 7'd51, 7'd43, 7'd35, 7'd27,
        7'd19, 7'd11, 7'd3,  7'd60, 7'd52, 7'd44, 7'd36,
        7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15,
        7'd7,  7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22,
        7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37, 7'd29,
        7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4
    };

    // pc2 subkey compression, source bit numbers into cd counted from the msb
    localparam tab_entry_t PC2_TAB [SUB_W] = '{
        7'd14, 7'd17, 7'd11, 7'd24, 7'd1,  7'd5,
        7'd3,  7'd28, 7'd15, 7'd6,  7'd21, 7'd10,
        7'd23, 7'd19, 7'd12, 7'd4,  7'd26, 7'd8,
        7'd16, 7'd7,  7'd27, 7'd20, 7'd13, 7'd2,
        7'd41, 7'd52, 7'd31, 7'd37, 7'd47, 7'd55,
        7'd30, 7'd40, 7'd51, 7'd45, 7'd33, 7'd48,
        7'd44, 7'd49, 7'd39, 7'd56, 7'd34, 7'd53,
        7'd46, 7'd42, 7'd50, 7'd36, 7'd29, 7'd32
    };

    // rounds that rotate by two places (bit r set), the others rotate by one
    localparam logic [ROUNDS-1:0] ROT_TWO = 16'b0111_1110_1111_1100;

    // item handed from front queue to back sequencer
    typedef struct packed {
        logic            valid;
        logic [CD_W-1:0] cd;
    } cd_item_t;

    function automatic logic [CD_W-1:0] pc1(input logic [KEY_W-1:0] key);
        logic [CD_W-1:0] res;
        res = '0;
        for (int i = 0; i < CD_W; i++) begin
            res[CD_W-1-i] = key[KEY_W - int'(PC1_TAB[i])];
        end
        return res;
    endfunction

    function automatic logic [SUB_W-1:0] pc2(input logic [CD_W-1:0] cd);
        logic [SUB_W-1:0] res;
        res = '0;
        for (int i = 0; i < SUB_W; i++) begin
            res[SUB_W-1-i] = cd[CD_W - int'(PC2_TAB[i])];
        end
        return res;
    endfunction

    function automatic logic [HALF_W-1:0] rot_half(input logic [HALF_W-1:0] h,
                                                   input logic two);
        logic [HALF_W-1:0] res;
        if (two) begin
            res = {h[HALF_W-3:0], h[HALF_W-1:HALF_W-2]};
        end
        else begin
            res = {h[HALF_W-2:0], h[HALF_W-1]};
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== src/des_key_schedule.sv =====
// path: a queued key moves to the halves registers when the sequencer is free,
// then its subkeys to the result register, one per cycle while pop is held high
// throughput: set by the single round sequencer, issuing one subkey per cycle
// while the result register is free; a two-slot key queue feeds it
// reset: rst_n asynchronous active low, empties the queue and the result register
`timescale 1ns / 1ps
`default_nettype none

module des_key_schedule (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       push,
    output logic                            full,
    input  wire logic [dks_pkg::KEY_W-1:0]  key_in,
    output logic                            empty,
    input  wire logic                       pop,
    output logic [dks_pkg::SUB_W-1:0]       round_key,
    output logic [dks_pkg::RNUM_W-1:0]      round_number,
    output logic                            last_round
);
    import dks_pkg::*;

    cd_item_t item;
    logic     take;

    // key intake and pc1 key selection
    dks_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .key_in (key_in),
        .item   (item),
        .take   (take)
    );

    // round generation and result register
    dks_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .take         (take),
        .empty        (empty),
        .pop          (pop),
        .round_key    (round_key),
        .round_number (round_number),
        .last_round   (last_round)
    );

endmodule

`default_nettype wire

// ===== src/dks_front.sv =====
// front of the key schedule: takes key transactions, applies the pc1 key selection
// and holds the halves in a two-slot queue; depends on dks_pkg
`timescale 1ns / 1ps
`default_nettype none

module dks_front (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     push,
    output logic                          full,
    input  wire logic [dks_pkg::KEY_W-1:0] key_in,
    output dks_pkg::cd_item_t             item,
    input  wire logic                     take
);
    import dks_pkg::*;

    logic [CD_W-1:0] slot_reg [2];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      count_reg, count_next;
    logic            do_push;
    logic            do_take;

    // handshake on both sides of the queue
    assign full    = (count_reg == 2'd2);
    assign do_push = push && !full;
    assign do_take = take && (count_reg != 2'd0);

    assign item.valid = (count_reg != 2'd0);
    assign item.cd    = slot_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_take;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // slot write with the pc1 key selection applied on entry
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= pc1(key_in);
        end
    end

endmodule

`default_nettype wire

// ===== src/dks_back.sv =====
// back of the key schedule: rotates the halves round by round and applies
// the pc2 compression into the result register; depends on dks_pkg and macros
`timescale 1ns / 1ps
`default_nettype none
`include "des_key_schedule_macros.svh"

module dks_back (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire dks_pkg::cd_item_t          item,
    output logic                            take,
    output logic                            empty,
    input  wire logic                       pop,
    output logic [dks_pkg::SUB_W-1:0]       round_key,
    output logic [dks_pkg::RNUM_W-1:0]      round_number,
    output logic                            last_round
);
    import dks_pkg::*;

    logic [HALF_W-1:0] c_reg, c_next;
    logic [HALF_W-1:0] d_reg, d_next;
    logic [RND_W-1:0]  round_reg, round_next;
    logic              busy_reg, busy_next;
    logic              out_valid_reg, out_valid_next;
    logic [SUB_W-1:0]  key_out_reg;
    logic [RNUM_W-1:0] rnum_out_reg;
    logic              last_out_reg;
    logic              advance;
    logic              issue;
    logic              final_issue;
    logic [HALF_W-1:0] c_rot;
    logic [HALF_W-1:0] d_rot;

    // result register frees when empty or when its transaction is taken
    assign advance     = !out_valid_reg || pop;
    assign issue       = busy_reg && advance;
    assign final_issue = issue && (round_reg == RND_W'(ROUNDS - 1));
    assign take        = item.valid && (!busy_reg || final_issue);

    assign c_rot = rot_half(c_reg, ROT_TWO[round_reg]);
    assign d_rot = rot_half(d_reg, ROT_TWO[round_reg]);

    // round sequencer
    always_comb
    begin
        c_next         = c_reg;
        d_next         = d_reg;
        round_next     = round_reg;
        busy_next      = busy_reg;
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = busy_reg;
        end
        if (issue)
        begin
            c_next     = c_rot;
            d_next     = d_rot;
            round_next = round_reg + RND_W'(1);
            if (final_issue)
            begin
                busy_next = 1'b0;
            end
        end
        if (take)
        begin
            c_next     = item.cd[CD_W-1:HALF_W];
            d_next     = item.cd[HALF_W-1:0];
            round_next = '0;
            busy_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            round_reg     <= '0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            round_reg     <= round_next;
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // halves and result payload
    always_ff @(posedge clk)
    begin
        c_reg <= c_next;
        d_reg <= d_next;
        if (issue)
        begin
            key_out_reg  <= pc2({c_rot, d_rot});
            rnum_out_reg <= {1'b0, round_reg} + RNUM_W'(1);
            last_out_reg <= (round_reg == RND_W'(ROUNDS - 1));
        end
    end

    assign empty        = !out_valid_reg;
    assign round_key    = key_out_reg;
    assign round_number = rnum_out_reg;
    assign last_round   = last_out_reg;

    // checks
    `DKS_ASSERT_IMP(a_last_is_sixteen, out_valid_reg && last_out_reg,
                    rnum_out_reg == RNUM_W'(ROUNDS))
    `DKS_ASSERT_NEXT(a_rounds_follow, out_valid_reg && !last_out_reg && pop,
                     out_valid_reg && rnum_out_reg == $past(rnum_out_reg) + RNUM_W'(1))
    `DKS_ASSERT_IMP(a_idle_holds_last, !busy_reg, !out_valid_reg || last_out_reg)

endmodule

`default_nettype wire
